// ===== design/sparse_row_slot_matrix_engine_assert.svh =====
// assertion macros for the sparse row-slot matrix engine
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SPARSE_ROW_SLOT_MATRIX_ENGINE_ASSERT_SVH
`define SPARSE_ROW_SLOT_MATRIX_ENGINE_ASSERT_SVH

// checked only while out of reset
`define SRSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SRSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/srsm_pkg.sv =====
// shared command codes and fixed-point helpers for the sparse row-slot engine
// no dependencies
package srsm_pkg;

  localparam logic [2:0] CMD_SET  = 3'd0;
  localparam logic [2:0] CMD_GET  = 3'd1;
  localparam logic [2:0] CMD_SCALE = 3'd2;
  localparam logic [2:0] CMD_LOAD = 3'd3;
  localparam logic [2:0] CMD_DOT  = 3'd4;

  localparam int unsigned ColW  = 10;
  localparam int unsigned ValW  = 32;
  localparam int unsigned ProdW = 48;
  localparam int unsigned AccW  = 52;

  // saturate a shifted product to q16.16
  function automatic logic signed [ValW-1:0] sat_prod(input logic signed [ProdW-1:0] v);
    logic signed [ValW-1:0] r;
    r = v[ValW-1:0];
    if (!v[ProdW-1] && (|v[ProdW-2:ValW-1])) r = {1'b0, {(ValW-1){1'b1}}};
    if (v[ProdW-1] && !(&v[ProdW-2:ValW-1])) r = {1'b1, {(ValW-1){1'b0}}};
    return r;
  endfunction

  // saturate the dot accumulator to q16.16
  function automatic logic signed [ValW-1:0] sat_acc(input logic signed [AccW-1:0] v);
    logic signed [ValW-1:0] r;
    r = v[ValW-1:0];
    if (!v[AccW-1] && (|v[AccW-2:ValW-1])) r = {1'b0, {(ValW-1){1'b1}}};
    if (v[AccW-1] && !(&v[AccW-2:ValW-1])) r = {1'b1, {(ValW-1){1'b0}}};
    return r;
  endfunction

endpackage

// ===== design/srsm_mul.sv =====
// registered q16.16 multiplier: full 64-bit product, floor shift by 16
// depends on srsm_pkg
module srsm_mul (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [srsm_pkg::ValW-1:0]        a_i,
  input  logic signed [srsm_pkg::ValW-1:0]        b_i,
  output logic signed [srsm_pkg::ProdW-1:0]       prod_o
);
  import srsm_pkg::*;

  logic signed [2*ValW-1:0] full;
  logic signed [ProdW-1:0]  prod_q;

  assign full = a_i * b_i;

  // dropping the low 16 bits of a two's complement value rounds toward minus infinity
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[2*ValW-1:16];
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== design/sparse_row_slot_matrix_engine.sv =====
// Sparse matrix store with SLOTS_PER_ROW packed (column, value) slots per row, plus a
// dense vector, with set, get, scale, vector load and row dot commands. After reset a
// clearing pass zeroes the fill counts and the vector; no beat is taken during it.
// Every command first reads the row's fill count. A set or get then scans the
// occupied slots of the row through the slot memory, and a delete moves each later
// slot down one place; a row dot goes through slot read, vector read, multiply and
// accumulate for each slot. Scale rewrites every slot of the memory, reading,
// multiplying and writing each in turn. One command is in work at a time; the result
// sits in an output register so the next beat can be taken while it waits.
// depends on srsm_pkg, srsm_mul and sparse_row_slot_matrix_engine_assert.svh
module sparse_row_slot_matrix_engine #(
  parameter int unsigned ROWS          = 1024,
  parameter int unsigned COLS          = 1024,
  parameter int unsigned SLOTS_PER_ROW = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [2:0]                                cmd_i,
  input  logic [9:0]                                row_i,
  input  logic [9:0]                                column_i,
  input  logic signed [31:0]                        value_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [31:0]                        value_out_o,
  output logic [$clog2(SLOTS_PER_ROW+1)-1:0]        row_fill_o,
  output logic                                      status_o
);
  import srsm_pkg::*;

  localparam int unsigned Depth = ROWS * SLOTS_PER_ROW;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned FW    = $clog2(SLOTS_PER_ROW + 1);
  localparam int unsigned ClrN  = (ROWS > COLS) ? ROWS : COLS;
  localparam int unsigned ClrW  = $clog2(ClrN + 1);
  localparam int unsigned SlotW = ColW + ValW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_SCRD  = 4'd9;
  localparam logic [3:0] S_SCMUL = 4'd10;
  localparam logic [3:0] S_SCWR  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // memories
  logic [SlotW-1:0] slot_mem [Depth];
  logic [FW-1:0]    fill_mem [ROWS];
  logic [ValW-1:0]  vec_mem  [COLS];

  logic [3:0]              state_q, state_d;
  logic [ClrW-1:0]         clr_q, clr_d;
  logic [2:0]              cmd_q, cmd_d;
  logic [9:0]              col_q, col_d;
  logic signed [ValW-1:0]  val_q, val_d;
  logic [RW-1:0]           ridx_q, ridx_d;
  logic                    rok_q, rok_d;
  logic [AW-1:0]           base_q, base_d;
  logic [FW-1:0]           k_q, k_d;
  logic [FW-1:0]           fill_q, fill_d;
  logic [AW-1:0]           sc_q, sc_d;
  logic                    cok_q, cok_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ValW-1:0]  res_q, res_d;
  logic                    stat_q, stat_d;
  logic                    ovalid_q, ovalid_d;
  logic signed [ValW-1:0]  oval_q, oval_d;
  logic [FW-1:0]           ofill_q, ofill_d;
  logic                    ostat_q, ostat_d;

  logic               slot_re, slot_we;
  logic [AW-1:0]      slot_raddr, slot_waddr;
  logic [SlotW-1:0]   slot_wdata, slot_rd_q;
  logic               fill_re, fill_we;
  logic [RW-1:0]      fill_raddr, fill_waddr;
  logic [FW-1:0]      fill_wdata, fill_rd_q;
  logic               vec_re, vec_we;
  logic [CW-1:0]      vec_raddr, vec_waddr;
  logic [ValW-1:0]    vec_wdata, vec_rd_q;

  logic                    mul_en;
  logic signed [ValW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  logic [9:0]             rd_col;
  logic signed [ValW-1:0] rd_val;
  logic [AW-1:0]          k_addr;

  assign rd_col = slot_rd_q[SlotW-1:ValW];
  assign rd_val = slot_rd_q[ValW-1:0];
  assign k_addr = base_q + AW'(k_q);

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rd_q <= fill_mem[fill_raddr];
    if (vec_we)  vec_mem[vec_waddr] <= vec_wdata;
    if (vec_re)  vec_rd_q <= vec_mem[vec_raddr];
  end

  srsm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    col_d   = col_q;
    val_d   = val_q;
    ridx_d  = ridx_q;
    rok_d   = rok_q;
    base_d  = base_q;
    k_d     = k_q;
    fill_d  = fill_q;
    sc_d    = sc_q;
    cok_d   = cok_q;
    acc_d   = acc_q;
    res_d   = res_q;
    stat_d  = stat_q;
    ovalid_d = ovalid_q;
    oval_d  = oval_q;
    ofill_d = ofill_q;
    ostat_d = ostat_q;

    slot_re = 1'b0;  slot_raddr = k_addr;
    slot_we = 1'b0;  slot_waddr = k_addr;  slot_wdata = {col_q, val_q};
    fill_re = 1'b0;  fill_raddr = RW'(row_i);
    fill_we = 1'b0;  fill_waddr = ridx_q;  fill_wdata = fill_q;
    vec_re  = 1'b0;  vec_raddr  = CW'(rd_col);
    vec_we  = 1'b0;  vec_waddr  = CW'(col_q);  vec_wdata = val_q;
    mul_en  = 1'b0;  mul_a = rd_val;  mul_b = val_q;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        fill_we    = (32'(clr_q) < ROWS);
        fill_waddr = RW'(clr_q);
        fill_wdata = '0;
        vec_we     = (32'(clr_q) < COLS);
        vec_waddr  = CW'(clr_q);
        vec_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (32'(clr_q) == ClrN - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          fill_re = 1'b1;
          cmd_d   = cmd_i;
          col_d   = column_i;
          val_d   = value_i;
          ridx_d  = RW'(row_i);
          rok_d   = (32'(row_i) < ROWS);
          base_d  = AW'(32'(row_i) * SLOTS_PER_ROW);
          k_d     = '0;
          acc_d   = '0;
          res_d   = '0;
          stat_d  = 1'b0;
          sc_d    = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        fill_d = rok_q ? fill_rd_q : '0;
        case (cmd_q) inside
          CMD_SET, CMD_GET, CMD_DOT: state_d = rok_q ? S_SCAN : S_DONE;
          CMD_SCALE: state_d = S_SCRD;
          CMD_LOAD: begin
            vec_we  = (32'(col_q) < COLS);
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (k_q == fill_q) begin
          // end of the occupied slots without a match
          state_d = S_DONE;
          if (cmd_q == CMD_DOT) begin
            res_d = sat_acc(acc_q);
          end else if (cmd_q == CMD_SET && val_q != '0) begin
            if (32'(fill_q) < SLOTS_PER_ROW) begin
              slot_we    = 1'b1;
              fill_d     = fill_q + 1'b1;
              fill_we    = 1'b1;
              fill_wdata = fill_q + 1'b1;
            end else begin
              stat_d = 1'b1;
            end
          end
        end else begin
          slot_re = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (cmd_q == CMD_DOT) begin
          vec_re  = 1'b1;
          cok_d   = (32'(rd_col) < COLS);
          state_d = S_MUL;
        end else if (rd_col == col_q) begin
          if (cmd_q == CMD_GET) begin
            res_d   = rd_val;
            state_d = S_DONE;
          end else if (val_q != '0) begin
            slot_we = 1'b1;
            state_d = S_DONE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_SHIFT;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (k_q == fill_q) begin
          fill_d     = fill_q - 1'b1;
          fill_we    = 1'b1;
          fill_wdata = fill_q - 1'b1;
          state_d    = S_DONE;
        end else begin
          slot_re = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        // move slot k down one place
        slot_we    = 1'b1;
        slot_waddr = k_addr - 1'b1;
        slot_wdata = slot_rd_q;
        k_d        = k_q + 1'b1;
        state_d    = S_SHIFT;
      end
      S_MUL: begin
        mul_en  = 1'b1;
        mul_b   = cok_q ? signed'(vec_rd_q) : '0;
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d   = acc_q + AccW'(prod);
        k_d     = k_q + 1'b1;
        state_d = S_SCAN;
      end
      S_SCRD: begin
        slot_re    = 1'b1;
        slot_raddr = sc_q;
        state_d    = S_SCMUL;
      end
      S_SCMUL: begin
        mul_en  = 1'b1;
        state_d = S_SCWR;
      end
      S_SCWR: begin
        // slots past the fill count are scaled too; they are never read before rewritten
        slot_we    = 1'b1;
        slot_waddr = sc_q;
        slot_wdata = {rd_col, sat_prod(prod)};
        sc_d       = sc_q + 1'b1;
        state_d    = (32'(sc_q) == Depth - 1) ? S_DONE : S_SCRD;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oval_d   = res_q;
          ofill_d  = fill_q;
          ostat_d  = stat_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      fill_q   <= '0;
      sc_q     <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      fill_q   <= fill_d;
      sc_q     <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    col_q   <= col_d;
    val_q   <= val_d;
    ridx_q  <= ridx_d;
    rok_q   <= rok_d;
    base_q  <= base_d;
    cok_q   <= cok_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    oval_q  <= oval_d;
    ofill_q <= ofill_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o = ovalid_q;
  assign value_out_o = oval_q;
  assign row_fill_o  = ofill_q;
  assign status_o    = ostat_q;

`include "sparse_row_slot_matrix_engine_assert.svh"

  `SRSM_ASSERT(a_accept_reads_fill, (in_valid_i && in_ready_o) |=> (state_q == S_FILL),
               "beat taken but fill count not read")
  `SRSM_ASSERT(a_fill_bound, (state_q != S_CLEAR) |-> (32'(fill_q) <= SLOTS_PER_ROW),
               "fill count beyond slot count")
  `SRSM_ASSERT(a_scan_bound, (state_q == S_SCAN || state_q == S_SHIFT) |-> (k_q <= fill_q),
               "slot index past fill count")
  `SRSM_ASSERT(a_no_write_idle, slot_we |-> (state_q != S_IDLE && state_q != S_CLEAR),
               "slot write outside a command")
  `SRSM_ASSERT_ALWAYS(a_no_accept_clear, (state_q == S_CLEAR) |-> !in_ready_o,
                      "beat taken during clearing pass")

endmodule
